// ----- hdl/cctd_pkg.sv -----
// Shared types and codes for the CNF clause tautology / duplicate filter.
// No dependencies; imported by the top level.
package cctd_pkg;

    // literal width on both streams
    localparam int LIT_W = 12;

    // terminator error codes
    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_OVERFLOW = 2'd1,
        ERR_RANGE    = 2'd2
    } t_err;

    // controller states, one-hot
    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_CHECK = 6'b000100,
        S_FETCH = 6'b001000,
        S_EMIT  = 6'b010000,
        S_TERM  = 6'b100000
    } t_state;

    // one output word
    typedef struct packed {
        logic [LIT_W-1:0] lit;
        logic             last;
        t_err             err;
    } t_out_word;

endpackage

// ----- hdl/cctd_mark_mem.sv -----
// Mark (stamp) store: one write port, two registered read ports.
// Standalone; used by cnf_clause_tautology_dedup_filter.
module cctd_mark_mem #(
    parameter int DEPTH = 2049,
    parameter int AW    = 12,
    parameter int DW    = 16
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr_a,
    input  logic [AW-1:0] i_rd_addr_b,
    output logic [DW-1:0] o_rd_data_a,
    output logic [DW-1:0] o_rd_data_b,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_a;
    logic [DW-1:0] r_rd_b;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // two read ports, data registered when i_rd_en is high
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_a <= r_mem[i_rd_addr_a];
            r_rd_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

// ----- hdl/cctd_clause_buf.sv -----
// Clause buffer: kept literals of the open clause, one write and one
// registered read port. Standalone; used by the top level.
module cctd_clause_buf #(
    parameter int DEPTH = 32,
    parameter int AW    = 5,
    parameter int DW    = 12
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read every cycle; the addressed word is registered onto o_rd_data
    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd;

endmodule

// ----- hdl/cnf_clause_tautology_dedup_filter.sv -----
// Top level of the CNF clause filter: controller, output register and the
// two memories. Depends on cctd_pkg, cctd_mark_mem and cctd_clause_buf.
//
//  channel   dir  tdata                    tlast          tuser
//  s_axis    in   [11:0] literal           -              -
//  m_axis    out  [11:0] out_literal       last           [1:0] error_code
//
// A nonzero literal goes through S_CHECK: the mark store is read at the
// literal and its negation, then written back in the check cycle. An
// out-of-range literal or a dropped (tautological) clause end is handled in S_IDLE.
// A kept clause end steps through S_FETCH (clause buffer read) and S_EMIT
// once per kept literal, then S_TERM; S_EMIT and S_TERM wait while m_axis stalls.
// After reset, and after every 2^STAMP_BITS-1 clauses when the stamp wraps,
// the mark store is cleared one entry a cycle, all 2*min(MAX_VARS,2048)+1
// entries, with s_axis tready low. Reset is synchronous, active low.
module cnf_clause_tautology_dedup_filter
    import cctd_pkg::*;
#(
    parameter int MAX_VARS       = 1024,
    parameter int MAX_CLAUSE_LEN = 32,
    parameter int STAMP_BITS     = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [11:0] literal, [15:12] zero
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [11:0] out_literal, [15:12] zero
    output logic        o_m_axis_tlast,   // last
    output logic [1:0]  o_m_axis_tuser    // [1:0] error_code
);

    // a 12-bit literal never reaches past magnitude 2048
    localparam int EFF   = (MAX_VARS < 2048) ? MAX_VARS : 2048;
    localparam int DEPTH = 2 * EFF + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int KW    = $clog2(MAX_CLAUSE_LEN + 1);
    localparam int BW    = (MAX_CLAUSE_LEN > 1) ? $clog2(MAX_CLAUSE_LEN) : 1;

    t_state                  r_state, n_state;
    logic [STAMP_BITS-1:0]   r_stamp, n_stamp;
    logic [KW-1:0]           r_kept, n_kept;
    logic [KW-1:0]           r_idx, n_idx;
    logic                    r_taut, n_taut;
    t_err                    r_err, n_err;
    logic [AW-1:0]           r_clr, n_clr;
    logic [AW-1:0]           r_pos;
    logic [LIT_W-1:0]        r_lit;
    logic                    r_out_valid, n_out_valid;
    t_out_word               r_out, n_out;

    logic                    w_accept;
    logic [LIT_W-1:0]        w_lit;
    logic [LIT_W-1:0]        w_mag;
    logic                    w_range_bad;
    logic signed [13:0]      w_lit_ext;
    logic signed [13:0]      w_pos_full;
    logic signed [13:0]      w_neg_full;
    logic [AW-1:0]           w_pos;
    logic [AW-1:0]           w_neg;
    logic                    w_out_free;
    logic [STAMP_BITS-1:0]   w_stamp_inc;

    logic [STAMP_BITS-1:0]   w_rd_pos;
    logic [STAMP_BITS-1:0]   w_rd_neg;
    logic                    w_mk_we;
    logic [AW-1:0]           w_mk_waddr;
    logic [STAMP_BITS-1:0]   w_mk_wdata;
    logic                    w_bf_we;
    logic [LIT_W-1:0]        w_bf_rdata;

    // input decode
    assign w_lit       = i_s_axis_tdata[LIT_W-1:0];
    assign w_mag       = w_lit[LIT_W-1] ? (~w_lit + 12'd1) : w_lit;
    assign w_range_bad = 32'(w_mag) > 32'(MAX_VARS);
    assign w_lit_ext   = {{2{w_lit[LIT_W-1]}}, w_lit};
    assign w_pos_full  = 14'(EFF) + w_lit_ext;
    assign w_neg_full  = 14'(EFF) - w_lit_ext;
    assign w_pos       = w_pos_full[AW-1:0];
    assign w_neg       = w_neg_full[AW-1:0];

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_stamp_inc     = r_stamp + 1'b1;

    // mark store: read both polarities on accept
    cctd_mark_mem #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (STAMP_BITS)
    ) u_mark (
        .i_clk       (i_clk),
        .i_rd_en     (w_accept),
        .i_rd_addr_a (w_pos),
        .i_rd_addr_b (w_neg),
        .o_rd_data_a (w_rd_pos),
        .o_rd_data_b (w_rd_neg),
        .i_wr_en     (w_mk_we),
        .i_wr_addr   (w_mk_waddr),
        .i_wr_data   (w_mk_wdata)
    );

    // clearing pass writes zero, check cycle writes the stamp
    always_comb begin
        w_mk_we    = 1'b0;
        w_mk_waddr = r_pos;
        w_mk_wdata = r_stamp;
        if (r_state == S_CLEAR) begin
            w_mk_we    = 1'b1;
            w_mk_waddr = r_clr;
            w_mk_wdata = '0;
        end else if (r_state == S_CHECK && w_rd_pos != r_stamp) begin
            w_mk_we = 1'b1;
        end
    end

    assign w_bf_we = (r_state == S_CHECK) && (w_rd_pos != r_stamp)
                     && (r_kept < KW'(MAX_CLAUSE_LEN));

    cctd_clause_buf #(
        .DEPTH (MAX_CLAUSE_LEN),
        .AW    (BW),
        .DW    (LIT_W)
    ) u_buf (
        .i_clk     (i_clk),
        .i_wr_en   (w_bf_we),
        .i_wr_addr (r_kept[BW-1:0]),
        .i_wr_data (r_lit),
        .i_rd_addr (r_idx[BW-1:0]),
        .o_rd_data (w_bf_rdata)
    );

    // controller
    always_comb begin
        n_state     = r_state;
        n_stamp     = r_stamp;
        n_kept      = r_kept;
        n_idx       = r_idx;
        n_taut      = r_taut;
        n_err       = r_err;
        n_clr       = r_clr;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + 1'b1;
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    if (w_lit != '0) begin
                        if (w_range_bad) begin
                            if (r_err == ERR_NONE) begin
                                n_err = ERR_RANGE;
                            end
                        end else begin
                            n_state = S_CHECK;
                        end
                    end else if (r_taut) begin
                        // tautology: drop the clause and its error
                        n_kept  = '0;
                        n_taut  = 1'b0;
                        n_err   = ERR_NONE;
                        n_stamp = w_stamp_inc;
                        if (w_stamp_inc == '0) begin
                            n_stamp = STAMP_BITS'(1);
                            n_clr   = '0;
                            n_state = S_CLEAR;
                        end
                    end else begin
                        n_idx   = '0;
                        n_state = (r_kept == '0) ? S_TERM : S_FETCH;
                    end
                end
            end
            S_CHECK: begin
                if (w_rd_neg == r_stamp) begin
                    n_taut = 1'b1;
                end
                if (w_rd_pos != r_stamp) begin
                    if (r_kept < KW'(MAX_CLAUSE_LEN)) begin
                        n_kept = r_kept + 1'b1;
                    end else if (r_err == ERR_NONE) begin
                        n_err = ERR_OVERFLOW;
                    end
                end
                n_state = S_IDLE;
            end
            S_FETCH: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out.lit   = w_bf_rdata;
                    n_out.last  = 1'b0;
                    n_out.err   = ERR_NONE;
                    n_idx       = r_idx + 1'b1;
                    n_state     = (r_idx + 1'b1 == r_kept) ? S_TERM : S_FETCH;
                end
            end
            S_TERM: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out.lit   = '0;
                    n_out.last  = 1'b1;
                    n_out.err   = r_err;
                    n_kept      = '0;
                    n_taut      = 1'b0;
                    n_err       = ERR_NONE;
                    n_stamp     = w_stamp_inc;
                    n_state     = S_IDLE;
                    if (w_stamp_inc == '0) begin
                        n_stamp = STAMP_BITS'(1);
                        n_clr   = '0;
                        n_state = S_CLEAR;
                    end
                end
            end
            default: begin
                n_state = S_CLEAR;
                n_clr   = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_stamp     <= STAMP_BITS'(1);
            r_kept      <= '0;
            r_idx       <= '0;
            r_taut      <= 1'b0;
            r_err       <= ERR_NONE;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_stamp     <= n_stamp;
            r_kept      <= n_kept;
            r_idx       <= n_idx;
            r_taut      <= n_taut;
            r_err       <= n_err;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (w_accept) begin
            r_lit <= w_lit;
            r_pos <= w_pos;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'b0000, r_out.lit};
    assign o_m_axis_tlast  = r_out.last;
    assign o_m_axis_tuser  = r_out.err;

endmodule

// ----- tb/cctd_clause_checker.sv -----
// Checker for the CNF clause filter: watches both streams, predicts the
// output words of every clause and compares them. Depends on cctd_pkg.
module cctd_clause_checker
    import cctd_pkg::*;
#(
    parameter int MAX_VARS       = 1024,
    parameter int MAX_CLAUSE_LEN = 32,
    parameter int STAMP_BITS     = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    input  logic        i_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [11:0] literal, [15:12] zero
    input  logic        i_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [15:0] i_m_axis_tdata,   // [11:0] out_literal, [15:12] zero
    input  logic        i_m_axis_tlast,   // last
    input  logic [1:0]  i_m_axis_tuser,   // [1:0] error_code
    output int          o_fail_count,
    output int          o_pending
);

    localparam int SEEN_DEPTH = 2 * MAX_VARS + 1;

    // predictor state
    logic [STAMP_BITS-1:0]  seen_stamp [SEEN_DEPTH];
    logic [STAMP_BITS-1:0]  cur_stamp;
    logic signed [LIT_W-1:0] kept_lits [MAX_CLAUSE_LEN];
    int                     n_kept;
    bit                     is_tautology;
    t_err                   clause_err;

    // words still owed by the block, oldest first
    t_out_word clause_words_due[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d, expected %0d", what, got, want);
        o_fail_count++;
    endtask

    task automatic wipe_marks();
        foreach (seen_stamp[i])
            seen_stamp[i] = '0;
    endtask

    task automatic reset_clause();
        n_kept       = 0;
        is_tautology = 1'b0;
        clause_err   = ERR_NONE;
    endtask

    task automatic note_error(input t_err code);
        if (clause_err == ERR_NONE)
            clause_err = code;
    endtask

    // feed one accepted literal into the prediction
    task automatic absorb_literal(input logic signed [LIT_W-1:0] lit);
        int        v;
        int        mag;
        int        pos_idx;
        int        neg_idx;
        t_out_word w;
        v = lit;
        if (v != 0) begin
            mag = (v < 0) ? -v : v;
            if (mag > MAX_VARS) begin
                note_error(ERR_RANGE);
            end else begin
                pos_idx = MAX_VARS + v;
                neg_idx = MAX_VARS - v;
                if (seen_stamp[neg_idx] == cur_stamp)
                    is_tautology = 1'b1;
                // duplicates are dropped silently
                if (seen_stamp[pos_idx] != cur_stamp) begin
                    seen_stamp[pos_idx] = cur_stamp;
                    if (n_kept < MAX_CLAUSE_LEN) begin
                        kept_lits[n_kept] = lit;
                        n_kept++;
                    end else begin
                        note_error(ERR_OVERFLOW);
                    end
                end
            end
        end else begin
            // terminator: a clean clause drains, a tautology vanishes
            if (!is_tautology) begin
                for (int k = 0; k < n_kept; k++) begin
                    w.lit  = kept_lits[k];
                    w.last = 1'b0;
                    w.err  = ERR_NONE;
                    clause_words_due.push_back(w);
                end
                w.lit  = '0;
                w.last = 1'b1;
                w.err  = clause_err;
                clause_words_due.push_back(w);
            end
            reset_clause();
            cur_stamp = cur_stamp + 1'b1;
            if (cur_stamp == '0) begin
                wipe_marks();
                cur_stamp = STAMP_BITS'(1);
            end
        end
    endtask

    // compare one output word with the oldest prediction
    task automatic check_word();
        t_out_word want;
        if (clause_words_due.size() == 0) begin
            report_mismatch("unexpected word, literal", $signed(i_m_axis_tdata[LIT_W-1:0]), 0);
        end else begin
            want = clause_words_due.pop_front();
            if (i_m_axis_tdata[LIT_W-1:0] !== want.lit)
                report_mismatch("literal", $signed(i_m_axis_tdata[LIT_W-1:0]),
                                $signed(want.lit));
            if (i_m_axis_tdata[15:LIT_W] !== '0)
                report_mismatch("tdata pad", i_m_axis_tdata[15:LIT_W], 0);
            if (i_m_axis_tlast !== want.last)
                report_mismatch("last", i_m_axis_tlast, want.last);
            if (i_m_axis_tuser !== want.err)
                report_mismatch("error code", i_m_axis_tuser, want.err);
        end
    endtask

    // sample both channels at the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            wipe_marks();
            cur_stamp = STAMP_BITS'(1);
            reset_clause();
            clause_words_due.delete();
        end else begin
            if (i_m_axis_tvalid && i_m_axis_tready)
                check_word();
            if (i_s_axis_tvalid && i_s_axis_tready)
                absorb_literal(i_s_axis_tdata[LIT_W-1:0]);
        end
        o_pending = clause_words_due.size();
    end

endmodule

// ----- tb/tb_cnf_clause_tautology_dedup_filter.sv -----
// Testbench top for the CNF clause filter: clock, reset, literal stimulus
// and output back-pressure. Depends on cctd_pkg, the block and cctd_clause_checker.
module tb_cnf_clause_tautology_dedup_filter;
    import cctd_pkg::*;

    localparam int MAX_VARS       = 1024;
    localparam int MAX_CLAUSE_LEN = 32;
    localparam int STAMP_BITS     = 16;
    localparam int RANDOM_ITEMS   = 280;
    // covers the clearing pass after reset plus the longest gaps
    localparam int IDLE_LIMIT     = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [15:0] i_s_axis_tdata;   // [11:0] literal, [15:12] zero
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [15:0] o_m_axis_tdata;   // [11:0] out_literal, [15:12] zero
    logic        o_m_axis_tlast;   // last
    logic [1:0]  o_m_axis_tuser;   // [1:0] error_code

    int fail_count;
    int words_owed;
    int items_sent;
    int idle_cycles;
    bit calm;

    // extremes, duplicates, tautologies, range errors, empty clause
    int directed_lits[$] = '{
        0,
        1024, -1, 0,
        -1024, 1, 1, 0,
        5, -5, 0,
        3, 2047, 0,
        -2048, 0,
        2000, 7, -7, 0
    };

    cnf_clause_tautology_dedup_filter #(
        .MAX_VARS       (MAX_VARS),
        .MAX_CLAUSE_LEN (MAX_CLAUSE_LEN),
        .STAMP_BITS     (STAMP_BITS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    cctd_clause_checker #(
        .MAX_VARS       (MAX_VARS),
        .MAX_CLAUSE_LEN (MAX_CLAUSE_LEN),
        .STAMP_BITS     (STAMP_BITS)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_m_axis_tdata  (o_m_axis_tdata),
        .i_m_axis_tlast  (o_m_axis_tlast),
        .i_m_axis_tuser  (o_m_axis_tuser),
        .o_fail_count    (fail_count),
        .o_pending       (words_owed)
    );

    // clock
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // per-word wait; calm stretches have none
    function automatic int pick_gap();
        return calm ? 0 : $urandom_range(0, 14);
    endfunction

    // mostly a small pool so duplicates and tautologies show up
    function automatic int pick_var();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(1, MAX_VARS)
                                           : $urandom_range(1, 16);
    endfunction

    // present one literal word and hold it until accepted
    task automatic send_lit(input int lit);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = {4'b0, lit[LIT_W-1:0]};
        do @(posedge i_clk); while (!o_s_axis_tready);
        @(negedge i_clk);
        items_sent++;
    endtask

    // output back-pressure
    initial begin
        int gap;
        i_m_axis_tready = 1'b0;
        forever begin
            gap = pick_gap();
            if (gap > 0) begin
                i_m_axis_tready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_m_axis_tready = 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
            @(negedge i_clk);
        end
    end

    // watchdog on cycles without any word moving
    initial idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // stimulus and verdict
    initial begin
        int  kind;
        int  len;
        int  v;
        bit  flip;
        bit  first_random;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        calm            = 1'b0;
        items_sent      = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_lits[k])
            send_lit(directed_lits[k]);

        // hold off until every owed word has come out
        i_s_axis_tvalid = 1'b0;
        while (words_owed != 0) @(negedge i_clk);

        // random clauses
        first_random = 1'b1;
        while (items_sent < RANDOM_ITEMS) begin
            calm = ($urandom_range(0, 5) == 0);
            kind = first_random ? 80 : $urandom_range(0, 99);
            first_random = 1'b0;
            flip = $urandom_range(0, 1);
            if (kind < 60) begin
                // clean clause: one sign per variable, duplicates allowed
                len = $urandom_range(1, 8);
                repeat (len) begin
                    v = pick_var();
                    send_lit(((v ^ flip) & 1) ? -v : v);
                end
            end else if (kind < 75) begin
                // free signs over a tiny pool, often a tautology
                len = $urandom_range(2, 8);
                repeat (len) begin
                    v = $urandom_range(1, 8);
                    send_lit($urandom_range(0, 1) ? -v : v);
                end
            end else if (kind < 85) begin
                // long clause around the buffer size
                len = $urandom_range(MAX_CLAUSE_LEN - 2, MAX_CLAUSE_LEN + 8);
                repeat (len) begin
                    v = $urandom_range(1, MAX_VARS);
                    send_lit(((v ^ flip) & 1) ? -v : v);
                end
            end else if (kind < 95) begin
                // raw 12-bit noise, out-of-range values included
                len = $urandom_range(1, 6);
                repeat (len) begin
                    v = $urandom_range(0, 4095);
                    send_lit((v > 2047) ? v - 4096 : v);
                end
            end
            send_lit(0);
        end
        i_s_axis_tvalid = 1'b0;
        calm = 1'b0;

        // drain, then let stray words show up
        while (words_owed != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);

        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
